### sv/mmn_pkg.sv
// mmn_pkg: shared types and constants of the min-max normalizer
// transaction payload structs, opcodes, digit width and status structs
// no dependencies
package mmn_pkg;

    localparam int SAMPLE_W      = 32;
    localparam int OUT_FRAC_BITS = 16;
    localparam int NORM_W        = OUT_FRAC_BITS + 1;
    localparam int DIGIT_BITS    = 4;
    localparam int QCNT_W        = $clog2(OUT_FRAC_BITS);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_SCAN  = 2'd1;
    localparam logic [1:0] OP_NORM  = 2'd2;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_valid;
    } req_t;

    typedef struct packed {
        logic [NORM_W-1:0] normalized;
        logic              result_valid;
    } rsp_t;

    typedef struct packed {
        logic borrow;
        logic zero;
    } sub_flags_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### sv/mmn_serial_sub.sv
// mmn_serial_sub: digit-serial subtractor, least significant digit first
// keeps the running borrow and a zero flag of the difference
// depends on mmn_pkg
module mmn_serial_sub
    import mmn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  en,
    input  logic [DIGIT_BITS-1:0] a,
    input  logic [DIGIT_BITS-1:0] b,
    output logic [DIGIT_BITS-1:0] diff,
    output sub_flags_t            flags
);

    logic                borrow_reg;
    logic                zero_reg;
    logic [DIGIT_BITS:0] wide;

    assign wide = {1'b0, a} - {1'b0, b} - {{DIGIT_BITS{1'b0}}, borrow_reg};
    assign diff = wide[DIGIT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            borrow_reg <= 1'b0;
            zero_reg   <= 1'b1;
        end
        else if (start)
        begin
            borrow_reg <= 1'b0;
            zero_reg   <= 1'b1;
        end
        else if (en)
        begin
            borrow_reg <= wide[DIGIT_BITS];
            zero_reg   <= zero_reg && (wide[DIGIT_BITS-1:0] == '0);
        end
    end

    assign flags.borrow = borrow_reg;
    assign flags.zero   = zero_reg;

endmodule

### sv/mmn_frac_div.sv
// mmn_frac_div: restoring fraction divider, one quotient bit per cycle
// computes num/den with OUT_FRAC_BITS bits for num < den
// depends on mmn_pkg
module mmn_frac_div
    import mmn_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [W-1:0]             num,
    input  logic [W-1:0]             den,
    output logic [OUT_FRAC_BITS-1:0] quot,
    output div_status_t              status
);

    logic [W-1:0]             rem_reg;
    logic [W-1:0]             den_reg;
    logic [OUT_FRAC_BITS-1:0] q_reg;
    logic [QCNT_W-1:0]        cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [W:0]               shifted;
    logic                     ge;
    logic [W:0]               reduced;

    // remainder stays below den, so the shifted value fits in W+1 bits
    assign shifted = {rem_reg, 1'b0};
    assign ge      = shifted >= {1'b0, den_reg};
    assign reduced = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= num;
                den_reg  <= den;
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? reduced[W-1:0] : shifted[W-1:0];
                q_reg   <= {q_reg[OUT_FRAC_BITS-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == QCNT_W'(OUT_FRAC_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot        = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### sv/minmax_normalizer.sv
// normalize: accept, digit-serial compare over ceil(SAMPLE_BITS/4) digits, decision,
// divider (16 quotient bits and the done flag), output register; clamped or no-data
// results skip the divider; scan: accept, digit-serial compare, decision; clear and the
// seeding scan finish in the accept state; the next transaction is accepted while a result
// waits in the output; reset (rst_n, async, active low) empties the tracker and output
module minmax_normalizer
    import mmn_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int NDIG     = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PAD_BITS = NDIG * DIGIT_BITS;
    localparam int CNT_W    = (NDIG > 1) ? $clog2(NDIG) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SER,
        S_EVAL,
        S_DIV,
        S_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [SAMPLE_BITS-1:0]  min_reg, min_next;
    logic [SAMPLE_BITS-1:0]  max_reg, max_next;
    logic                    seen_reg, seen_next;
    logic [SAMPLE_BITS-1:0]  raw_reg, raw_next;
    logic                    norm_reg, norm_next;
    logic [PAD_BITS-1:0]     s_sh_reg, s_sh_next;
    logic [PAD_BITS-1:0]     lo_sh_reg, lo_sh_next;
    logic [PAD_BITS-1:0]     hi_sh_reg, hi_sh_next;
    logic [PAD_BITS-1:0]     num_sh_reg, num_sh_next;
    logic [PAD_BITS-1:0]     rng_sh_reg, rng_sh_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [NORM_W-1:0]       res_reg, res_next;
    logic                    res_ok_reg, res_ok_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    logic                    sub_start;
    logic                    sub_en;
    logic                    div_start;
    logic [SAMPLE_BITS-1:0]  req_raw;
    logic [DIGIT_BITS-1:0]   d_s_lo, d_hi_s, d_hi_lo;
    sub_flags_t              f_s_lo, f_hi_s, f_hi_lo;
    logic [OUT_FRAC_BITS-1:0] quot;
    div_status_t             div_status;

    // flipping the sign bit gives offset binary, ordered under unsigned compare
    function automatic logic [PAD_BITS-1:0] biased(input logic [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS-1:0] b;
        b = {~v[SAMPLE_BITS-1], v[SAMPLE_BITS-2:0]};
        return PAD_BITS'(b);
    endfunction

    assign req_raw = SAMPLE_BITS'($unsigned(req.sample));

    mmn_serial_sub u_sub_s_lo (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sub_start),
        .en    (sub_en),
        .a     (s_sh_reg[DIGIT_BITS-1:0]),
        .b     (lo_sh_reg[DIGIT_BITS-1:0]),
        .diff  (d_s_lo),
        .flags (f_s_lo)
    );

    mmn_serial_sub u_sub_hi_s (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sub_start),
        .en    (sub_en),
        .a     (hi_sh_reg[DIGIT_BITS-1:0]),
        .b     (s_sh_reg[DIGIT_BITS-1:0]),
        .diff  (d_hi_s),
        .flags (f_hi_s)
    );

    mmn_serial_sub u_sub_hi_lo (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sub_start),
        .en    (sub_en),
        .a     (hi_sh_reg[DIGIT_BITS-1:0]),
        .b     (lo_sh_reg[DIGIT_BITS-1:0]),
        .diff  (d_hi_lo),
        .flags (f_hi_lo)
    );

    mmn_frac_div #(
        .W (SAMPLE_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (num_sh_reg[SAMPLE_BITS-1:0]),
        .den    (rng_sh_reg[SAMPLE_BITS-1:0]),
        .quot   (quot),
        .status (div_status)
    );

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        seen_next      = seen_reg;
        raw_next       = raw_reg;
        norm_next      = norm_reg;
        s_sh_next      = s_sh_reg;
        lo_sh_next     = lo_sh_reg;
        hi_sh_next     = hi_sh_reg;
        num_sh_next    = num_sh_reg;
        rng_sh_next    = rng_sh_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_ok_next    = res_ok_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        sub_start      = 1'b0;
        sub_en         = 1'b0;
        div_start      = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    raw_next   = req_raw;
                    s_sh_next  = biased(req_raw);
                    lo_sh_next = biased(min_reg);
                    hi_sh_next = biased(max_reg);
                    cnt_next   = '0;
                    case (req.opcode)
                        OP_CLEAR:
                        begin
                            min_next  = '0;
                            max_next  = '0;
                            seen_next = 1'b0;
                        end
                        OP_SCAN:
                        begin
                            if (req.sample_valid && !seen_reg)
                            begin
                                min_next  = req_raw;
                                max_next  = req_raw;
                                seen_next = 1'b1;
                            end
                            else if (req.sample_valid)
                            begin
                                norm_next  = 1'b0;
                                sub_start  = 1'b1;
                                state_next = S_SER;
                            end
                        end
                        OP_NORM:
                        begin
                            if (req.sample_valid && seen_reg)
                            begin
                                norm_next  = 1'b1;
                                sub_start  = 1'b1;
                                state_next = S_SER;
                            end
                            else
                            begin
                                res_next    = '0;
                                res_ok_next = 1'b0;
                                state_next  = S_OUT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SER:
            begin
                sub_en      = 1'b1;
                s_sh_next   = s_sh_reg >> DIGIT_BITS;
                lo_sh_next  = lo_sh_reg >> DIGIT_BITS;
                hi_sh_next  = hi_sh_reg >> DIGIT_BITS;
                num_sh_next = {d_s_lo, num_sh_reg[PAD_BITS-1:DIGIT_BITS]};
                rng_sh_next = {d_hi_lo, rng_sh_reg[PAD_BITS-1:DIGIT_BITS]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NDIG - 1))
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!norm_reg)
                begin
                    if (f_s_lo.borrow)
                    begin
                        min_next = raw_reg;
                    end
                    if (f_hi_s.borrow)
                    begin
                        max_next = raw_reg;
                    end
                    state_next = S_IDLE;
                end
                else if (f_hi_lo.borrow || f_hi_lo.zero)
                begin
                    // zero range
                    res_next    = '0;
                    res_ok_next = 1'b0;
                    state_next  = S_OUT;
                end
                else if (f_s_lo.borrow || f_s_lo.zero)
                begin
                    res_next    = '0;
                    res_ok_next = 1'b1;
                    state_next  = S_OUT;
                end
                else if (f_hi_s.borrow || f_hi_s.zero)
                begin
                    // at or above max saturates to one
                    res_next    = {1'b1, {OUT_FRAC_BITS{1'b0}}};
                    res_ok_next = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    res_next    = {1'b0, quot};
                    res_ok_next = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.normalized   = res_reg;
                    rsp_next.result_valid = res_ok_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_reg       <= '0;
            max_reg       <= '0;
            seen_reg      <= 1'b0;
            raw_reg       <= '0;
            norm_reg      <= 1'b0;
            s_sh_reg      <= '0;
            lo_sh_reg     <= '0;
            hi_sh_reg     <= '0;
            num_sh_reg    <= '0;
            rng_sh_reg    <= '0;
            cnt_reg       <= '0;
            res_reg       <= '0;
            res_ok_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            seen_reg      <= seen_next;
            raw_reg       <= raw_next;
            norm_reg      <= norm_next;
            s_sh_reg      <= s_sh_next;
            lo_sh_reg     <= lo_sh_next;
            hi_sh_reg     <= hi_sh_next;
            num_sh_reg    <= num_sh_next;
            rng_sh_reg    <= rng_sh_next;
            cnt_reg       <= cnt_next;
            res_reg       <= res_next;
            res_ok_reg    <= res_ok_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### sv/mmn_checker.sv
// mmn_checker: port-level assertions for minmax_normalizer
// bound to the top level below; depends on mmn_pkg
module mmn_checker
    import mmn_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // a stalled result keeps its transaction
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // no-data results carry a zero fraction
    a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.result_valid |-> rsp.normalized == '0)
        else $error("no-data result with nonzero fraction");

    // the fraction never exceeds one
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.normalized <= {1'b1, {OUT_FRAC_BITS{1'b0}}})
        else $error("fraction above one");

    // clear and scan transactions produce no result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.opcode != OP_NORM |=> !$rose(rsp_valid))
        else $error("result after a non-normalize transaction");

    // a normalize transaction occupies the block
    a_norm_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.opcode == OP_NORM |=> !req_ready)
        else $error("ready right after a normalize transaction");

endmodule

bind minmax_normalizer mmn_checker u_mmn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
